@@ design/assert_macros.svh @@
// Concurrent assertion helpers, sampled on the rising edge of clock and
// switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/wavhp_pkg.sv @@
package wavhp_pkg;

   typedef enum logic [2:0] {
      PH_PREAMBLE,
      PH_HEADER,
      PH_FMT,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_NOT_WAVE,
      STATUS_FMT_SHORT,
      STATUS_NOT_PCM,
      STATUS_DATA_EARLY,
      STATUS_TRUNCATED
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] sample_bits;
      logic [31:0] data_length;
      logic [31:0] data_start;
   } result_type;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;
   localparam logic [15:0] PCM_TAG  = 16'd1;
   localparam logic [31:0] FMT_MIN  = 32'd16;

   localparam logic [3:0] IDX_RIFF_END  = 4'd3;
   localparam logic [3:0] IDX_WAVE_END  = 4'd11;
   localparam logic [3:0] IDX_TAG_END   = 4'd3;
   localparam logic [3:0] IDX_HDR_END   = 4'd7;
   localparam logic [3:0] IDX_RATE_END  = 4'd7;
   localparam logic [3:0] IDX_BITS_LO   = 4'd14;
   localparam logic [3:0] IDX_FMT_END   = 4'd15;

endpackage

@@ design/wavhp_rsp_buf.sv @@
module wavhp_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wavhp_pkg::result_type  push_data,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output wavhp_pkg::result_type  out_data
);

   logic                  main_valid_ff;
   logic                  skid_valid_ff;
   wavhp_pkg::result_type main_data_ff;
   wavhp_pkg::result_type skid_data_ff;
   logic                  pop;

   assign pop       = main_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // promote the waiting transaction once the head leaves
         if (pop) begin
            main_data_ff  <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push && (!main_valid_ff || pop)) begin
         main_data_ff  <= push_data;
         main_valid_ff <= 1'b1;
      end else if (push) begin
         skid_data_ff  <= push_data;
         skid_valid_ff <= 1'b1;
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

@@ design/wav_header_parser_unit.sv @@
// WAV header parser: one file byte per transaction, parsed in a single pass.
// Each result is registered in the response buffer and shown on rsp_ from its head.
// Throughput: one byte per cycle; the per-byte step is one shallow decode
// plus a 33-bit skip counter. req_ready drops only while two results back up.
// Reset (synchronous, active high) clears the parser and empties the outputs.
module wav_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_of_file,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_sample_bits,
   output logic [31:0] rsp_data_length,
   output logic [31:0] rsp_data_start
);

   wavhp_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [3:0]  idx_ff, idx_in, idx_cur;
   logic [31:0] tag_ff, tag_in, tag_cur;
   logic [31:0] len_ff, len_in, len_cur;
   logic [32:0] skip_ff, skip_in, skip_cur;
   logic        fmt_seen_ff, fmt_seen_in, fmt_seen_cur;
   logic [31:0] pos_ff, pos_in, pos_cur;
   logic [15:0] chan_ff, chan_in, chan_cur;
   logic [31:0] rate_ff, rate_in, rate_cur;
   logic [15:0] bits_ff, bits_in, bits_cur;
   logic        bad_ff, bad_in, bad_cur;
   logic [7:0]  byte14_ff, byte14_in, byte14_cur;

   logic                  req_accept;
   logic                  emit;
   wavhp_pkg::status_type emit_status;
   wavhp_pkg::result_type result;
   wavhp_pkg::result_type rsp_data;
   logic [32:0]           skip_len;
   logic [32:0]           skip_dec;

   assign req_accept = req_valid & req_ready;

   // a restart clears the state before the byte is handled
   always_comb begin
      if (req_first_of_file) begin
         phase_cur    = wavhp_pkg::PH_PREAMBLE;
         idx_cur      = '0;
         tag_cur      = '0;
         len_cur      = '0;
         skip_cur     = '0;
         fmt_seen_cur = 1'b0;
         pos_cur      = '0;
         chan_cur     = '0;
         rate_cur     = '0;
         bits_cur     = '0;
         bad_cur      = 1'b0;
         byte14_cur   = '0;
      end else begin
         phase_cur    = phase_ff;
         idx_cur      = idx_ff;
         tag_cur      = tag_ff;
         len_cur      = len_ff;
         skip_cur     = skip_ff;
         fmt_seen_cur = fmt_seen_ff;
         pos_cur      = pos_ff;
         chan_cur     = chan_ff;
         rate_cur     = rate_ff;
         bits_cur     = bits_ff;
         bad_cur      = bad_ff;
         byte14_cur   = byte14_ff;
      end
   end

   assign skip_dec = (skip_cur != '0) ? skip_cur - 33'd1 : skip_cur;

   always_comb begin
      phase_in    = phase_cur;
      idx_in      = idx_cur;
      tag_in      = tag_cur;
      len_in      = len_cur;
      skip_in     = skip_cur;
      fmt_seen_in = fmt_seen_cur;
      pos_in      = pos_cur;
      chan_in     = chan_cur;
      rate_in     = rate_cur;
      bits_in     = bits_cur;
      bad_in      = bad_cur;
      byte14_in   = byte14_cur;
      emit        = 1'b0;
      emit_status = wavhp_pkg::STATUS_OK;
      skip_len    = '0;

      if (req_end_of_file) begin
         if (phase_cur != wavhp_pkg::PH_DONE) begin
            emit        = 1'b1;
            emit_status = wavhp_pkg::STATUS_TRUNCATED;
         end
      end else if (phase_cur != wavhp_pkg::PH_DONE) begin
         if (pos_cur != '1) begin
            pos_in = pos_cur + 32'd1;
         end
         idx_in = idx_cur + 4'd1;
         case (phase_cur)
            wavhp_pkg::PH_PREAMBLE: begin
               tag_in = {tag_cur[23:0], req_byte_value};
               if (idx_cur == wavhp_pkg::IDX_RIFF_END && tag_in != wavhp_pkg::TAG_RIFF) begin
                  bad_in = 1'b1;
               end
               if (idx_cur == wavhp_pkg::IDX_WAVE_END) begin
                  idx_in = '0;
                  if (bad_in || tag_in != wavhp_pkg::TAG_WAVE) begin
                     emit        = 1'b1;
                     emit_status = wavhp_pkg::STATUS_NOT_WAVE;
                  end else begin
                     phase_in = wavhp_pkg::PH_HEADER;
                  end
               end
            end
            wavhp_pkg::PH_HEADER: begin
               if (idx_cur <= wavhp_pkg::IDX_TAG_END) begin
                  tag_in = {tag_cur[23:0], req_byte_value};
               end else begin
                  len_in = {req_byte_value, len_cur[31:8]};
               end
               if (idx_cur == wavhp_pkg::IDX_HDR_END) begin
                  idx_in = '0;
                  if (tag_cur == wavhp_pkg::TAG_FMT) begin
                     if (len_in < wavhp_pkg::FMT_MIN) begin
                        emit        = 1'b1;
                        emit_status = wavhp_pkg::STATUS_FMT_SHORT;
                     end else begin
                        phase_in = wavhp_pkg::PH_FMT;
                     end
                  end else if (tag_cur == wavhp_pkg::TAG_DATA) begin
                     emit        = 1'b1;
                     emit_status = fmt_seen_cur ? wavhp_pkg::STATUS_OK
                                                : wavhp_pkg::STATUS_DATA_EARLY;
                  end else begin
                     // unknown chunk: skip body and pad byte
                     skip_len = {1'b0, len_in} + {32'd0, len_in[0]};
                     skip_in  = skip_len;
                     phase_in = (skip_len == '0) ? wavhp_pkg::PH_HEADER
                                                 : wavhp_pkg::PH_SKIP;
                  end
               end
            end
            wavhp_pkg::PH_FMT: begin
               if (idx_cur <= wavhp_pkg::IDX_TAG_END) begin
                  tag_in = {req_byte_value, tag_cur[31:8]};
               end else if (idx_cur <= wavhp_pkg::IDX_RATE_END) begin
                  skip_in = {1'b0, req_byte_value, skip_cur[31:8]};
               end else if (idx_cur == wavhp_pkg::IDX_BITS_LO) begin
                  byte14_in = req_byte_value;
               end
               if (idx_cur == wavhp_pkg::IDX_FMT_END) begin
                  idx_in  = '0;
                  chan_in = tag_cur[31:16];
                  rate_in = skip_cur[31:0];
                  bits_in = {req_byte_value, byte14_cur};
                  if (tag_cur[15:0] != wavhp_pkg::PCM_TAG) begin
                     emit        = 1'b1;
                     emit_status = wavhp_pkg::STATUS_NOT_PCM;
                  end else begin
                     fmt_seen_in = 1'b1;
                     // skip the extension and pad byte
                     skip_len = {1'b0, len_cur - wavhp_pkg::FMT_MIN} + {32'd0, len_cur[0]};
                     skip_in  = skip_len;
                     phase_in = (skip_len == '0) ? wavhp_pkg::PH_HEADER
                                                 : wavhp_pkg::PH_SKIP;
                  end
               end
            end
            wavhp_pkg::PH_SKIP: begin
               idx_in  = idx_cur;
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  idx_in   = '0;
                  phase_in = wavhp_pkg::PH_HEADER;
               end
            end
            default: begin
               idx_in = idx_cur;
            end
         endcase
      end

      if (emit) begin
         phase_in = wavhp_pkg::PH_DONE;
      end
   end

   always_comb begin
      result.status        = emit_status;
      result.channel_count = chan_in;
      result.sample_rate   = rate_in;
      result.sample_bits   = bits_in;
      result.data_length   = (emit_status == wavhp_pkg::STATUS_OK) ? len_in : '0;
      result.data_start    = (emit_status == wavhp_pkg::STATUS_OK) ? pos_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wavhp_pkg::PH_PREAMBLE;
         idx_ff      <= '0;
         tag_ff      <= '0;
         len_ff      <= '0;
         skip_ff     <= '0;
         fmt_seen_ff <= 1'b0;
         pos_ff      <= '0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         bad_ff      <= 1'b0;
         byte14_ff   <= '0;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         idx_ff      <= idx_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         skip_ff     <= skip_in;
         fmt_seen_ff <= fmt_seen_in;
         pos_ff      <= pos_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         bad_ff      <= bad_in;
         byte14_ff   <= byte14_in;
      end
   end

   wavhp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept & emit),
      .push_data (result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_status        = rsp_data.status;
   assign rsp_channel_count = rsp_data.channel_count;
   assign rsp_sample_rate   = rsp_data.sample_rate;
   assign rsp_sample_bits   = rsp_data.sample_bits;
   assign rsp_data_length   = rsp_data.data_length;
   assign rsp_data_start    = rsp_data.data_start;

`include "assert_macros.svh"

   `ASSERT_IMP(a_stall_means_full, clock, reset, !req_ready, rsp_valid)
   `ASSERT_NEXT(a_emit_ends_parse, clock, reset, req_accept && emit, phase_ff == wavhp_pkg::PH_DONE)
   `ASSERT_NEXT(a_pos_monotonic, clock, reset, req_accept && !req_first_of_file, pos_ff >= $past(pos_ff))
   `ASSERT_IMP(a_ok_after_headers, clock, reset, rsp_valid && rsp_status == wavhp_pkg::STATUS_OK, rsp_data_start >= 32'd20)

endmodule

@@ dv/wav_header_parser_check.sv @@
module wav_header_parser_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_of_file,
   input  logic        req_end_of_file,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_channel_count,
   input  logic [31:0] rsp_sample_rate,
   input  logic [15:0] rsp_sample_bits,
   input  logic [31:0] rsp_data_length,
   input  logic [31:0] rsp_data_start,
   output int unsigned header_errors,
   output int unsigned headers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // format tag and channel count share the first fmt word
   localparam logic [3:0] IDX_WORD_END = 4'd3;

   wavhp_pkg::phase_type parse_phase;
   logic [3:0]  byte_pos;
   logic [31:0] tag_shift;
   logic [31:0] body_length;
   logic [32:0] bytes_to_skip;
   logic [31:0] fmt_word;
   logic [31:0] rate_shift;
   logic [7:0]  bits_low;
   logic        fmt_valid;
   logic [31:0] file_offset;
   logic [15:0] format_code;
   logic [15:0] channels;
   logic [31:0] rate;
   logic [15:0] sample_width;
   logic        parse_done;
   logic        preamble_error;

   wavhp_pkg::result_type expected_headers[$];

   task automatic clear_parser();
      parse_phase     = wavhp_pkg::PH_PREAMBLE;
      byte_pos        = '0;
      tag_shift       = '0;
      body_length     = '0;
      bytes_to_skip   = '0;
      fmt_word        = '0;
      rate_shift      = '0;
      bits_low        = '0;
      fmt_valid       = 1'b0;
      file_offset     = '0;
      format_code     = '0;
      channels        = '0;
      rate            = '0;
      sample_width    = '0;
      parse_done      = 1'b0;
      preamble_error  = 1'b0;
   endtask

   task automatic finish_file(input wavhp_pkg::status_type st);
      wavhp_pkg::result_type hdr;
      hdr.status        = st;
      hdr.channel_count = channels;
      hdr.sample_rate   = rate;
      hdr.sample_bits   = sample_width;
      hdr.data_length   = (st == wavhp_pkg::STATUS_OK) ? body_length : '0;
      hdr.data_start    = (st == wavhp_pkg::STATUS_OK) ? file_offset : '0;
      expected_headers.push_back(hdr);
      parse_done  = 1'b1;
      parse_phase = wavhp_pkg::PH_DONE;
   endtask

   task automatic start_skip(input logic [32:0] count);
      bytes_to_skip = count;
      byte_pos      = '0;
      parse_phase   = (count == '0) ? wavhp_pkg::PH_HEADER : wavhp_pkg::PH_SKIP;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic first, input logic eof);
      if (first)
         clear_parser();
      if (eof) begin
         if (!parse_done)
            finish_file(wavhp_pkg::STATUS_TRUNCATED);
         return;
      end
      if (parse_done)
         return;
      if (file_offset != '1)
         file_offset++;
      case (parse_phase)
         wavhp_pkg::PH_PREAMBLE: begin
            tag_shift = {tag_shift[23:0], b};
            if (byte_pos == wavhp_pkg::IDX_RIFF_END && tag_shift != wavhp_pkg::TAG_RIFF)
               preamble_error = 1'b1;
            if (byte_pos == wavhp_pkg::IDX_WAVE_END) begin
               if (preamble_error || tag_shift != wavhp_pkg::TAG_WAVE) begin
                  finish_file(wavhp_pkg::STATUS_NOT_WAVE);
               end else begin
                  byte_pos    = '0;
                  parse_phase = wavhp_pkg::PH_HEADER;
               end
            end else begin
               byte_pos++;
            end
         end
         wavhp_pkg::PH_HEADER: begin
            if (byte_pos <= wavhp_pkg::IDX_TAG_END)
               tag_shift = {tag_shift[23:0], b};
            else
               body_length = {b, body_length[31:8]};
            if (byte_pos != wavhp_pkg::IDX_HDR_END) begin
               byte_pos++;
            end else begin
               byte_pos = '0;
               if (tag_shift == wavhp_pkg::TAG_FMT) begin
                  if (body_length < wavhp_pkg::FMT_MIN)
                     finish_file(wavhp_pkg::STATUS_FMT_SHORT);
                  else
                     parse_phase = wavhp_pkg::PH_FMT;
               end else if (tag_shift == wavhp_pkg::TAG_DATA) begin
                  finish_file(fmt_valid ? wavhp_pkg::STATUS_OK
                                        : wavhp_pkg::STATUS_DATA_EARLY);
               end else begin
                  // odd sizes carry one pad byte
                  start_skip({1'b0, body_length} + {32'd0, body_length[0]});
               end
            end
         end
         wavhp_pkg::PH_FMT: begin
            if (byte_pos <= IDX_WORD_END)
               fmt_word = {b, fmt_word[31:8]};
            else if (byte_pos <= wavhp_pkg::IDX_RATE_END)
               rate_shift = {b, rate_shift[31:8]};
            else if (byte_pos == wavhp_pkg::IDX_BITS_LO)
               bits_low = b;
            if (byte_pos != wavhp_pkg::IDX_FMT_END) begin
               byte_pos++;
            end else begin
               format_code     = fmt_word[15:0];
               channels        = fmt_word[31:16];
               rate            = rate_shift;
               sample_width    = {b, bits_low};
               if (format_code != wavhp_pkg::PCM_TAG) begin
                  finish_file(wavhp_pkg::STATUS_NOT_PCM);
               end else begin
                  fmt_valid = 1'b1;
                  start_skip({1'b0, body_length - wavhp_pkg::FMT_MIN}
                             + {32'd0, body_length[0]});
               end
            end
         end
         wavhp_pkg::PH_SKIP: begin
            if (bytes_to_skip != '0)
               bytes_to_skip--;
            if (bytes_to_skip == '0) begin
               byte_pos    = '0;
               parse_phase = wavhp_pkg::PH_HEADER;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         header_errors++;
      end
   endtask

   always @(posedge clock) begin
      wavhp_pkg::result_type want;
      if (reset) begin
         clear_parser();
         expected_headers.delete();
         header_errors = 0;
         headers_pending <= 0;
      end else begin
         // compare before predicting: a result never leaves in its own byte's cycle
         if (rsp_valid && rsp_ready) begin
            if (expected_headers.size() == 0) begin
               $error("status: expected no result, actual %0h", rsp_status);
               header_errors++;
            end else begin
               want = expected_headers.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("channel_count", 32'(want.channel_count),
                           32'(rsp_channel_count));
               check_field("sample_rate", want.sample_rate, rsp_sample_rate);
               check_field("sample_bits", 32'(want.sample_bits), 32'(rsp_sample_bits));
               check_field("data_length", want.data_length, rsp_data_length);
               check_field("data_start", want.data_start, rsp_data_start);
            end
         end
         if (req_valid && req_ready)
            parse_byte(req_byte_value, req_first_of_file, req_end_of_file);
         headers_pending <= expected_headers.size();
      end
   end

endmodule

@@ dv/tb_wav_header_parser_unit.sv @@
module tb_wav_header_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 300;
   localparam int DRAIN_LIMIT = 5000;
   localparam int MIN_BYTES   = 750;
   localparam int MIN_FILES   = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_value;
   logic        req_first_of_file;
   logic        req_end_of_file;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_sample_bits;
   logic [31:0] rsp_data_length;
   logic [31:0] rsp_data_start;
   int unsigned header_errors;
   int unsigned headers_pending;

   logic [7:0]  file_bytes[$];
   int          bytes_sent = 0;
   int          files_sent = 0;
   int          hold_requests = 0;
   bit          burst = 1'b0;

   always #5 clock = ~clock;

   wav_header_parser_unit dut (.*);

   wav_header_parser_check header_check (.*);

   // file assembly

   function automatic void put_le(input logic [31:0] v, input int n);
      for (int k = 0; k < n; k++)
         file_bytes.push_back(v[8*k +: 8]);
   endfunction

   function automatic void put_tag(input logic [31:0] t);
      for (int k = 3; k >= 0; k--)
         file_bytes.push_back(t[8*k +: 8]);
   endfunction

   function automatic void put_random(input int n);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [31:0] pick_value();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      return $urandom;
   endfunction

   // tags one bit away from the known ones exercise the tag compare
   function automatic logic [31:0] pick_tag();
      case ($urandom_range(0, 3))
         0: return wavhp_pkg::TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
         1: return wavhp_pkg::TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic void put_preamble();
      put_tag(wavhp_pkg::TAG_RIFF);
      put_le(pick_value(), 4);
      put_tag(wavhp_pkg::TAG_WAVE);
   endfunction

   function automatic void put_unknown(input logic [31:0] size);
      put_tag(pick_tag());
      put_le(size, 4);
      if (size < 64)
         put_random(int'(size) + int'(size[0]));
   endfunction

   // header and the 16-byte body only; any extension is up to the caller
   function automatic void put_fmt(input logic [31:0] size, input logic [15:0] code,
                                   input logic [31:0] chans, input logic [31:0] rate,
                                   input logic [31:0] bits);
      put_tag(wavhp_pkg::TAG_FMT);
      put_le(size, 4);
      put_le(32'(code), 2);
      put_le(chans, 2);
      put_le(rate, 4);
      put_random(6);
      put_le(bits, 2);
   endfunction

   function automatic void build_good_file();
      int ext;
      file_bytes.delete();
      put_preamble();
      repeat ($urandom_range(0, 2)) put_unknown($urandom_range(0, 7));
      ext = $urandom_range(0, 5);
      put_fmt(16 + ext, wavhp_pkg::PCM_TAG, pick_value(), pick_value(), pick_value());
      put_random(ext + ext % 2);
      if ($urandom_range(0, 3) == 0)
         put_unknown($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0)
         put_fmt(16, wavhp_pkg::PCM_TAG, pick_value(), pick_value(), pick_value());
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(pick_value(), 4);
      put_random($urandom_range(0, 4));
   endfunction

   // sending

   task automatic send_item(input logic [7:0] value, input logic first, input logic eof);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_byte_value    <= value;
      req_first_of_file <= first;
      req_end_of_file   <= eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file(input bit mark_first, input bit close_file);
      foreach (file_bytes[i])
         send_item(file_bytes[i], mark_first && i == 0, 1'b0);
      if (close_file)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      files_sent++;
   endtask

   task automatic send_empty_file();
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      files_sent++;
   endtask

   task automatic wait_for_results();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (headers_pending != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic send_random_file();
      int kind;
      int cut;
      int pos;
      logic [15:0] code;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         build_good_file();
         send_file(1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 65) begin
         // cut short; the last few leave the file open and rely on the next restart
         build_good_file();
         cut = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
         send_file(1'b1, kind < 62);
      end else if (kind < 71) begin
         build_good_file();
         pos = $urandom_range(0, 7);
         if (pos > 3)
            pos += 4;
         file_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
         send_file(1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 77) begin
         file_bytes.delete();
         put_preamble();
         if ($urandom_range(0, 1) == 0)
            put_unknown($urandom_range(0, 7));
         put_tag(wavhp_pkg::TAG_FMT);
         put_le($urandom_range(0, 15), 4);
         put_random($urandom_range(0, 8));
         send_file(1'b1, 1'b1);
      end else if (kind < 83) begin
         code = 16'($urandom);
         if (code == wavhp_pkg::PCM_TAG)
            code = 16'h0003;
         file_bytes.delete();
         put_preamble();
         put_fmt(16, code, pick_value(), pick_value(), pick_value());
         put_tag(wavhp_pkg::TAG_DATA);
         put_le(pick_value(), 4);
         send_file(1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 89) begin
         file_bytes.delete();
         put_preamble();
         repeat ($urandom_range(0, 1)) put_unknown($urandom_range(0, 7));
         put_tag(wavhp_pkg::TAG_DATA);
         put_le(pick_value(), 4);
         put_random($urandom_range(0, 4));
         send_file(1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 95) begin
         file_bytes.delete();
         put_random($urandom_range(1, 30));
         send_file(1'b1, 1'b1);
      end else begin
         send_empty_file();
      end
   endtask

   // receiver: random stalls, calm stretches and a long hold-off on request
   initial begin
      int stall;
      int calm;
      int holds_done;
      rsp_ready  = 1'b0;
      calm       = 0;
      holds_done = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         if (calm > 0) begin
            stall = 0;
            calm--;
         end else if ($urandom_range(0, 9) == 0) begin
            stall = 0;
            calm  = 20;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int file_no;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_byte_value    = '0;
      req_first_of_file = 1'b0;
      req_end_of_file   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // first file after reset carries no start marker
      file_bytes.delete();
      put_preamble();
      put_fmt(16, wavhp_pkg::PCM_TAG, 2, 44100, 16);
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(8, 4);
      send_file(1'b0, 1'b1);

      send_empty_file();

      build_good_file();
      file_bytes[3] ^= 8'h01;
      send_file(1'b1, 1'b1);
      build_good_file();
      file_bytes[11] ^= 8'h80;
      send_file(1'b1, 1'b1);

      for (int size = 0; size < 16; size += 15) begin
         file_bytes.delete();
         put_preamble();
         put_tag(wavhp_pkg::TAG_FMT);
         put_le(size, 4);
         put_random(4);
         send_file(1'b1, 1'b1);
      end

      file_bytes.delete();
      put_preamble();
      put_fmt(16, 16'hFFFE, 1, 48000, 24);
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(64, 4);
      send_file(1'b1, 1'b0);

      file_bytes.delete();
      put_preamble();
      put_unknown(3);
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(100, 4);
      send_file(1'b1, 1'b1);

      // odd and empty unknown chunks, fmt extension, all-ones values; trailing
      // bytes and a second end marker after the result are dropped
      file_bytes.delete();
      put_preamble();
      put_unknown(1);
      put_unknown(0);
      put_fmt(18, wavhp_pkg::PCM_TAG, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF);
      put_random(2);
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(32'hFFFF_FFFF, 4);
      put_random(3);
      send_file(1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);

      file_bytes.delete();
      put_preamble();
      put_fmt(16, wavhp_pkg::PCM_TAG, 1, 8000, 8);
      put_fmt(17, wavhp_pkg::PCM_TAG, 0, 0, 0);
      put_random(2);
      put_tag(wavhp_pkg::TAG_DATA);
      put_le(0, 4);
      send_file(1'b1, 1'b1);

      file_bytes.delete();
      put_preamble();
      put_fmt(20, wavhp_pkg::PCM_TAG, 2, 44100, 16);
      put_random(4);
      put_fmt(16, 16'h0000, 6, 96000, 32);
      send_file(1'b1, 1'b1);

      // huge skips, cut off by the end of file
      file_bytes.delete();
      put_preamble();
      put_unknown(32'hFFFF_FFFF);
      put_random(6);
      send_file(1'b1, 1'b1);
      file_bytes.delete();
      put_preamble();
      put_fmt(32'hFFFF_FFFF, wavhp_pkg::PCM_TAG, 2, 22050, 8);
      put_random(5);
      send_file(1'b1, 1'b1);

      // restart in the middle of a file
      build_good_file();
      while (file_bytes.size() > 20) void'(file_bytes.pop_back());
      send_file(1'b1, 1'b0);
      build_good_file();
      send_file(1'b1, 1'b1);

      wait_for_results();

      file_no = 0;
      while (bytes_sent < MIN_BYTES || files_sent < MIN_FILES) begin
         if (file_no == 0) begin
            // hold the receiver off and flood with empty files to back the block up
            hold_requests <= hold_requests + 1;
            burst = 1'b1;
            repeat (24) send_empty_file();
            wait_for_results();
         end
         burst = ($urandom_range(0, 9) == 0);
         send_random_file();
         file_no++;
      end
      burst = 1'b0;

      wait_for_results();
      repeat (8) @(posedge clock);
      if (header_errors == 0 && headers_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/wavhp_pkg.sv
design/wavhp_rsp_buf.sv
design/wav_header_parser_unit.sv
dv/wav_header_parser_check.sv
dv/tb_wav_header_parser_unit.sv
